### rtl/nfga_pkg.sv
`default_nettype none

package nfga_pkg;

  // Pool geometry.
  localparam int NODES = 256;
  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);

  // Field widths.
  localparam int LEN_W      = 20;
  localparam int OFF_W      = 20;
  localparam int LOG2_W     = 4;
  localparam int POOL_W     = 9;
  localparam int STAT_W     = 2;
  localparam int GRAN_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int MAX_LOG2   = 12;

  // Working widths for compares and for the offset shift.
  localparam int CMP_W   = LEN_W + CNT_W + 2;
  localparam int SHIFT_W = IDX_W + MAX_LOG2 + OFF_W;

  localparam logic [LOG2_W-1:0] LOG2_RESET = LOG2_W'(4);
  localparam logic [LOG2_W-1:0] LOG2_MAX   = LOG2_W'(MAX_LOG2);
  localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(256);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [GRAN_W-1:0] {
    G_FREE = 2'd0,
    G_HEAD = 2'd1,
    G_CONT = 2'd2
  } gran_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOROOM  = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRANULE_LOG2  = 1'b0,
    REG_POOL_GRANULES = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_MARK,
    S_FHEAD,
    S_FCONT,
    S_BACK,
    S_RESP
  } state_t;

  // Effective configuration after clamping.
  typedef struct packed {
    logic [LOG2_W-1:0] lg;
    logic [CNT_W-1:0]  cnt;
  } cfg_t;

  // Request from the engine to the granule map memory.
  typedef struct packed {
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [GRAN_W-1:0] wdata;
  } mem_req_t;

endpackage

`default_nettype wire

### rtl/nfga_ram.sv
`default_nettype none

module nfga_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] store [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/nfga_engine.sv
`default_nettype none

module nfga_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  nfga_pkg::cfg_t               cfg,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         kind,
  input  logic [nfga_pkg::LEN_W-1:0]   length,
  input  logic [nfga_pkg::OFF_W-1:0]   offset,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [nfga_pkg::STAT_W-1:0]  status,
  output logic [nfga_pkg::OFF_W-1:0]   block_offset,
  output nfga_pkg::mem_req_t           mem,
  input  logic [nfga_pkg::GRAN_W-1:0]  mem_rdata
);

  import nfga_pkg::*;

  state_t            state, state_next;
  logic              req_kind;
  logic [LEN_W-1:0]  req_length;
  logic [OFF_W-1:0]  req_offset;
  logic [CNT_W-1:0]  need;
  logic              pass;
  logic [IDX_W-1:0]  iss_pos;
  logic              iss_on;
  logic              ev_valid;
  logic [IDX_W-1:0]  ev_pos;
  logic [CNT_W-1:0]  run_len;
  logic [IDX_W-1:0]  run_start;
  logic [IDX_W-1:0]  mark_pos;
  logic [CNT_W-1:0]  mark_left;
  logic [IDX_W-1:0]  next_slot;
  logic [IDX_W-1:0]  clr_pos;
  status_t           res_status;
  logic [OFF_W-1:0]  res_offset;

  logic [IDX_W-1:0]   last_pos;
  logic               clr_last;
  logic [LEN_W:0]     gran_mask;
  logic [LEN_W:0]     need_wide;
  logic               len_zero;
  logic               no_room;
  logic [IDX_W-1:0]   start_pos;
  logic [OFF_W-1:0]   free_wide;
  logic               free_range_bad;
  logic [IDX_W-1:0]   free_pos;
  logic               g_free, g_head, g_cont;
  logic [CNT_W-1:0]   run_inc;
  logic               found;
  logic [IDX_W-1:0]   found_start;
  logic               pass_end;
  logic [CNT_W:0]     found_end;
  logic [SHIFT_W-1:0] found_shift;
  logic               next_in_pool;
  logic               slot_zero;
  logic [IDX_W-1:0]   slot_m1, slot_m2;
  logic               rsp_load;

  // Shared decode of the current request and of the memory read data.
  assign last_pos       = IDX_W'(cfg.cnt - CNT_W'(1));
  assign clr_last       = (clr_pos == IDX_W'(NODES - 1));
  assign gran_mask      = ~({(LEN_W + 1){1'b1}} << cfg.lg);
  assign need_wide      = ({1'b0, req_length} + gran_mask) >> cfg.lg;
  assign len_zero       = (req_length == '0);
  assign no_room        = (CMP_W'(need_wide) > CMP_W'(cfg.cnt));
  assign start_pos      = (CMP_W'(next_slot) < CMP_W'(cfg.cnt)) ? next_slot : '0;
  assign free_wide      = req_offset >> cfg.lg;
  assign free_range_bad = (CMP_W'(free_wide) >= CMP_W'(cfg.cnt));
  assign free_pos       = free_wide[IDX_W-1:0];

  assign g_free = (mem_rdata == G_FREE);
  assign g_head = (mem_rdata == G_HEAD);
  assign g_cont = (mem_rdata == G_CONT);

  // Run tracking for the next-fit scan.
  assign run_inc     = run_len + CNT_W'(1);
  assign found       = ev_valid && g_free && (run_inc == need);
  assign found_start = (run_len == '0) ? ev_pos : run_start;
  assign pass_end    = ev_valid && (ev_pos == last_pos);
  assign found_end   = (CNT_W + 1)'(found_start) + (CNT_W + 1)'(need);
  assign found_shift = SHIFT_W'(found_start) << cfg.lg;

  // Continuation walk and next-slot back-off.
  assign next_in_pool = (CMP_W'(ev_pos) + CMP_W'(1) < CMP_W'(cfg.cnt));
  assign slot_zero    = (next_slot == '0);
  assign slot_m1      = next_slot - IDX_W'(1);
  assign slot_m2      = slot_m1 - IDX_W'(1);

  assign rsp_load = (state == S_RESP) && (!rsp_valid || !rsp_stall);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_PREP;
      end
      S_PREP: begin
        if (req_kind == KIND_ALLOC) begin
          state_next = (len_zero || no_room) ? S_RESP : S_SCAN;
        end else begin
          state_next = free_range_bad ? S_RESP : S_FHEAD;
        end
      end
      S_SCAN: begin
        if (found) begin
          state_next = S_MARK;
        end else if (pass_end && pass) begin
          state_next = S_RESP;
        end
      end
      S_MARK: begin
        if (mark_left == CNT_W'(1)) state_next = S_RESP;
      end
      S_FHEAD: begin
        if (!g_head) begin
          state_next = S_RESP;
        end else begin
          state_next = next_in_pool ? S_FCONT : S_BACK;
        end
      end
      S_FCONT: begin
        if (!g_cont || !next_in_pool) state_next = S_BACK;
      end
      S_BACK: begin
        if (!ev_valid) begin
          if (slot_zero) state_next = S_RESP;
        end else if (!g_free || (slot_m1 == '0)) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (rsp_load) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Memory requests and input stall.
  always_comb begin
    mem       = '0;
    mem.wdata = G_FREE;
    req_stall = (state != S_IDLE);
    unique case (state)
      S_CLEAR: begin
        mem.we    = 1'b1;
        mem.waddr = clr_pos;
      end
      S_PREP: begin
        if (req_kind == KIND_FREE && !free_range_bad) begin
          mem.re    = 1'b1;
          mem.raddr = free_pos;
        end
      end
      S_SCAN: begin
        mem.re    = iss_on;
        mem.raddr = iss_pos;
      end
      S_MARK: begin
        mem.we    = 1'b1;
        mem.waddr = mark_pos;
        mem.wdata = (mark_left == need) ? G_HEAD : G_CONT;
      end
      S_FHEAD: begin
        if (g_head) begin
          mem.we    = 1'b1;
          mem.waddr = ev_pos;
          mem.re    = next_in_pool;
          mem.raddr = ev_pos + IDX_W'(1);
        end
      end
      S_FCONT: begin
        if (g_cont) begin
          mem.we    = 1'b1;
          mem.waddr = ev_pos;
          mem.re    = next_in_pool;
          mem.raddr = ev_pos + IDX_W'(1);
        end
      end
      S_BACK: begin
        if (!ev_valid) begin
          mem.re    = !slot_zero;
          mem.raddr = slot_m1;
        end else begin
          mem.re    = g_free && (slot_m1 != '0);
          mem.raddr = slot_m2;
        end
      end
      S_IDLE, S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_pos   <= '0;
      next_slot <= '0;
      ev_valid  <= 1'b0;
      iss_on    <= 1'b0;
      pass      <= 1'b0;
      run_len   <= '0;
      mark_left <= '0;
      need      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      ev_valid <= mem.re;
      case (state)
        S_CLEAR: begin
          clr_pos <= clr_pos + IDX_W'(1);
        end
        S_PREP: begin
          pass    <= 1'b0;
          iss_on  <= 1'b1;
          run_len <= '0;
          need    <= need_wide[CNT_W-1:0];
        end
        S_SCAN: begin
          if (iss_on) iss_on <= (iss_pos != last_pos);
          if (found) begin
            mark_left <= need;
            next_slot <= (found_end == (CNT_W + 1)'(cfg.cnt)) ? '0 : found_end[IDX_W-1:0];
          end else if (ev_valid) begin
            if (pass_end) begin
              pass    <= 1'b1;
              iss_on  <= 1'b1;
              run_len <= '0;
            end else begin
              run_len <= g_free ? run_inc : '0;
            end
          end
        end
        S_MARK: begin
          mark_left <= mark_left - CNT_W'(1);
        end
        S_BACK: begin
          if (ev_valid && g_free) next_slot <= slot_m1;
        end
        default: begin
        end
      endcase
      // The result register empties on a taken beat and refills from the engine.
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (mem.re) ev_pos <= mem.raddr;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          req_kind   <= kind;
          req_length <= length;
          req_offset <= offset;
        end
      end
      S_PREP: begin
        iss_pos    <= start_pos;
        res_offset <= '0;
        if (req_kind == KIND_ALLOC) begin
          if (len_zero) begin
            res_status <= ST_ZERO;
          end else if (no_room) begin
            res_status <= ST_NOROOM;
          end else begin
            res_status <= ST_OK;
          end
        end else begin
          res_status <= free_range_bad ? ST_BADFREE : ST_OK;
        end
      end
      S_SCAN: begin
        if (iss_on) iss_pos <= iss_pos + IDX_W'(1);
        if (ev_valid && g_free && (run_len == '0)) run_start <= ev_pos;
        if (found) begin
          mark_pos   <= found_start;
          res_offset <= found_shift[OFF_W-1:0];
        end else if (pass_end) begin
          iss_pos <= '0;
          if (pass) res_status <= ST_NOROOM;
        end
      end
      S_MARK: begin
        mark_pos <= mark_pos + IDX_W'(1);
      end
      S_FHEAD: begin
        if (!g_head) res_status <= ST_BADFREE;
      end
      S_RESP: begin
        if (rsp_load) begin
          status       <= res_status;
          block_offset <= res_offset;
        end
      end
      default: begin
      end
    endcase
  end

  // The map is never read and written at one address in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem.we && mem.re) |-> (mem.waddr != mem.raddr))
    else $error("granule map read and written at one address");

  // A run that reaches the need is taken at once, so a scan never sees a longer one.
  a_run_short: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && ev_valid) |-> (run_len < need))
    else $error("free run outgrew the request");

  // A block being marked lies wholly inside the pool.
  a_mark_fits: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> (CMP_W'(mark_pos) + CMP_W'(mark_left) <= CMP_W'(cfg.cnt)))
    else $error("marked block runs past the pool end");

  // A failed request or a free carries a zero block offset.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && (res_status != ST_OK || req_kind == KIND_FREE))
      |-> (res_offset == '0))
    else $error("nonzero offset on a result without an allocation");

endmodule

`default_nettype wire

### rtl/next_fit_granule_allocator_top.sv
// Allocate: after accept the engine prepares, scans the map for a free run, then marks
// the block's granules; the scan reads one granule a cycle from the map memory and makes
// at most two passes over the pool. Free clears the block's granules, then backs off the scan start.
// Throughput: one request in flight at a time; the next is accepted while the result waits.
// Reset: a clearing pass writes all NODES (256) map entries free with the
// request channel stalled; configuration writes are taken throughout.
`default_nettype none

module next_fit_granule_allocator_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nfga_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nfga_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             kind,
  input  logic [nfga_pkg::LEN_W-1:0]       length,
  input  logic [nfga_pkg::OFF_W-1:0]       offset,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [nfga_pkg::STAT_W-1:0]      status,
  output logic [nfga_pkg::OFF_W-1:0]       block_offset
);

  import nfga_pkg::*;

  logic [LOG2_W-1:0] granule_log2;
  logic [POOL_W-1:0] pool_granules;
  cfg_t              cfg;
  mem_req_t          mem_req;
  logic [GRAN_W-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      granule_log2  <= LOG2_RESET;
      pool_granules <= POOL_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRANULE_LOG2:  granule_log2  <= cfg_data[LOG2_W-1:0];
        REG_POOL_GRANULES: pool_granules <= cfg_data[POOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the granule size and the pool size to what the map supports.
  assign cfg.lg  = (granule_log2 > LOG2_MAX) ? LOG2_MAX : granule_log2;
  assign cfg.cnt = (CMP_W'(pool_granules) > CMP_W'(NODES)) ? CNT_W'(NODES)
                                                          : CNT_W'(pool_granules);

  nfga_ram #(
    .WIDTH (GRAN_W),
    .DEPTH (NODES)
  ) u_map (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  nfga_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .kind         (kind),
    .length       (length),
    .offset       (offset),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .block_offset (block_offset),
    .mem          (mem_req),
    .mem_rdata    (mem_rdata)
  );

endmodule

`default_nettype wire
